// ===== hw/rtl/ece_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Field widths, curve codes, bounce segment codes and the out-back constant
// shared by the pipeline stages.
// ----------------------------------------------------------------------------
package ece_pkg;

   localparam int CMD_W   = 4;
   localparam int IN_W    = 20;
   localparam int OUT_W   = 17;
   localparam int OUT_MAX = 131071;

   // Out-back overshoot 1.70158 with 32 fraction bits, rounded to nearest.
   localparam logic [33:0] BACK_C1_Q32 = 34'd7308230452;

   typedef enum logic [CMD_W-1:0] {
      CURVE_LINEAR     = 4'd0,
      CURVE_INQUAD     = 4'd1,
      CURVE_OUTQUAD    = 4'd2,
      CURVE_INOUTQUAD  = 4'd3,
      CURVE_INCUBIC    = 4'd4,
      CURVE_OUTCUBIC   = 4'd5,
      CURVE_INOUTCUBIC = 4'd6,
      CURVE_OUTBACK    = 4'd7,
      CURVE_OUTBOUNCE  = 4'd8
   } curve_type;

   typedef enum logic [1:0] {
      SEG_FIRST  = 2'd0,
      SEG_SECOND = 2'd1,
      SEG_THIRD  = 2'd2,
      SEG_LAST   = 2'd3
   } seg_type;

   // Curve code and the half of the curve the item falls in.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             upper;
   } ctl_type;

   // Out-back constant rounded to nearest at the given fraction width.
   function automatic logic [33:0] back_c1(input int frac_bits);
      logic [33:0] rnd;
      rnd = 34'(1) << (31 - frac_bits);
      return (BACK_C1_Q32 + rnd) >> (32 - frac_bits);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/easing_curve_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Returns the eased value of one of nine standard easing curves at progress t.
// A request beat carries a curve code (req_cmd) and t (req_progress, signed,
// FRAC_BITS fraction bits); t is clamped to 0..1. Codes above out-bounce
// return the clamped t. Each request produces one response beat on rsp_eased
// (unsigned, FRAC_BITS fraction bits, saturated to the 17-bit range), in order.
// The pipeline has five register stages: clamp and select, square, cube,
// constant multiply and the output register. It takes one beat per cycle
// while req_stall is low. When the receiver raises rsp_stall, the response
// and all queued beats hold; empty stages still fill, so req_stall rises
// only once every stage is full. Reset clears all valid bits; the data
// registers are not reset.
// ----------------------------------------------------------------------------
module easing_curve_evaluator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ece_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [ece_pkg::IN_W-1:0]     req_progress,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ece_pkg::OUT_W-1:0]           rsp_eased
);
   import ece_pkg::*;

   localparam int TW = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 4;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, out_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in, out_vld_in;
   logic en1, en2, en3, en4, en_out;

   // A stage loads when it is empty or when its contents move on.
   always_comb begin
      en_out     = !out_vld_ff || !rsp_stall;
      en4        = !s4_vld_ff || en_out;
      en3        = !s3_vld_ff || en4;
      en2        = !s2_vld_ff || en3;
      en1        = !s1_vld_ff || en2;
      s1_vld_in  = en1 ? req_valid : s1_vld_ff;
      s2_vld_in  = en2 ? s1_vld_ff : s2_vld_ff;
      s3_vld_in  = en3 ? s2_vld_ff : s3_vld_ff;
      s4_vld_in  = en4 ? s3_vld_ff : s4_vld_ff;
      out_vld_in = en_out ? s4_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign req_stall = !en1;
   assign rsp_valid = out_vld_ff;

   ctl_type       s1_ctl;
   logic [TW-1:0] s1_t;
   logic [TW-1:0] s1_x;
   logic [DW-1:0] s1_d;
   seg_type       s1_seg;

   ece_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock    (clock),
      .en       (en1),
      .cmd      (req_cmd),
      .progress (req_progress),
      .ctl_ff   (s1_ctl),
      .t_ff     (s1_t),
      .x_ff     (s1_x),
      .d_ff     (s1_d),
      .seg_ff   (s1_seg)
   );

   ctl_type       s2_ctl;
   logic [TW-1:0] s2_t;
   logic [TW-1:0] s2_x;
   logic [TW-1:0] s2_sq;
   logic [TW:0]   s2_bnc;

   ece_square #(.FRAC_BITS(FRAC_BITS)) u_square (
      .clock   (clock),
      .en      (en2),
      .src_ctl (s1_ctl),
      .src_t   (s1_t),
      .src_x   (s1_x),
      .src_d   (s1_d),
      .src_seg (s1_seg),
      .ctl_ff  (s2_ctl),
      .t_ff    (s2_t),
      .x_ff    (s2_x),
      .sq_ff   (s2_sq),
      .bnc_ff  (s2_bnc)
   );

   ctl_type       s3_ctl;
   logic [TW-1:0] s3_t;
   logic [TW-1:0] s3_sq;
   logic [TW-1:0] s3_cube;
   logic [TW-1:0] s3_c1sq;
   logic [TW:0]   s3_bnc;

   ece_cube #(.FRAC_BITS(FRAC_BITS)) u_cube (
      .clock   (clock),
      .en      (en3),
      .src_ctl (s2_ctl),
      .src_t   (s2_t),
      .src_x   (s2_x),
      .src_sq  (s2_sq),
      .src_bnc (s2_bnc),
      .ctl_ff  (s3_ctl),
      .t_ff    (s3_t),
      .sq_ff   (s3_sq),
      .cube_ff (s3_cube),
      .c1sq_ff (s3_c1sq),
      .bnc_ff  (s3_bnc)
   );

   ece_result #(.FRAC_BITS(FRAC_BITS)) u_result (
      .clock    (clock),
      .en_mul   (en4),
      .en_out   (en_out),
      .src_ctl  (s3_ctl),
      .src_t    (s3_t),
      .src_sq   (s3_sq),
      .src_cube (s3_cube),
      .src_c1sq (s3_c1sq),
      .src_bnc  (s3_bnc),
      .eased_ff (rsp_eased)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/ece_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator, input stage
// Clamps t to 0..1, picks the multiplier operand (t or 1 - t) and finds the
// bounce segment and its distance from the segment center.
// ----------------------------------------------------------------------------
module ece_prep #(
   parameter int FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [ece_pkg::CMD_W-1:0]           cmd,
   input  logic signed [ece_pkg::IN_W-1:0]     progress,
   output ece_pkg::ctl_type                    ctl_ff,
   output logic [FRAC_BITS:0]                  t_ff,
   output logic [FRAC_BITS:0]                  x_ff,
   output logic [FRAC_BITS+3:0]                d_ff,
   output ece_pkg::seg_type                    seg_ff
);
   import ece_pkg::*;

   localparam int TW = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 4;
   localparam int CW = (IN_W > TW) ? IN_W : TW;
   localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
   localparam logic [TW-1:0] ONE   = TW'(1) << FRAC_BITS;
   localparam logic [TW-1:0] HALF  = TW'(1) << (FRAC_BITS - 1);
   localparam logic [DW-1:0] B4    = DW'(4) << FRAC_BITS;
   localparam logic [DW-1:0] B6    = DW'(6) << FRAC_BITS;
   localparam logic [DW-1:0] B8    = DW'(8) << FRAC_BITS;
   localparam logic [DW-1:0] B9    = DW'(9) << FRAC_BITS;
   localparam logic [DW-1:0] B10   = DW'(10) << FRAC_BITS;
   localparam logic [DW-1:0] B21H  = DW'(21) << (FRAC_BITS - 1);

   logic [CW-1:0] raw;
   logic [TW-1:0] t_in;
   logic [TW-1:0] v;
   logic [TW-1:0] x_in;
   logic          use_v;
   ctl_type       ctl_in;
   logic [DW-1:0] t11;
   logic [DW-1:0] ctr;
   logic [DW-1:0] d_in;
   seg_type       seg_in;

   always_comb begin
      raw = CW'($unsigned(progress));
      if (progress[IN_W-1]) begin
         t_in = '0;
      end else if (raw > ONE_C) begin
         t_in = ONE;
      end else begin
         t_in = TW'(raw);
      end
      v = ONE - t_in;

      ctl_in.cmd   = cmd;
      ctl_in.upper = (t_in >= HALF);

      unique case (cmd) inside
         CURVE_OUTQUAD, CURVE_OUTCUBIC, CURVE_OUTBACK: use_v = 1'b1;
         CURVE_INOUTQUAD, CURVE_INOUTCUBIC:            use_v = ctl_in.upper;
         default:                                      use_v = 1'b0;
      endcase
      x_in = use_v ? v : t_in;

      // The last bounce segment uses 11t - 10.5 instead of 22t - 21; the square
      // is then a quarter as large, so all segments share one shift.
      t11 = (DW'(t_in) << 3) + (DW'(t_in) << 1) + DW'(t_in);
      if (t11 < B4) begin
         seg_in = SEG_FIRST;
         ctr    = '0;
      end else if (t11 < B8) begin
         seg_in = SEG_SECOND;
         ctr    = B6;
      end else if (t11 < B10) begin
         seg_in = SEG_THIRD;
         ctr    = B9;
      end else begin
         seg_in = SEG_LAST;
         ctr    = B21H;
      end
      d_in = (t11 >= ctr) ? (t11 - ctr) : (ctr - t11);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= ctl_in;
         t_ff   <= t_in;
         x_ff   <= x_in;
         d_ff   <= d_in;
         seg_ff <= seg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ece_square.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator, square stage
// Squares the operand with rounding and evaluates the bounce parabola.
// ----------------------------------------------------------------------------
module ece_square #(
   parameter int FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  ece_pkg::ctl_type      src_ctl,
   input  logic [FRAC_BITS:0]    src_t,
   input  logic [FRAC_BITS:0]    src_x,
   input  logic [FRAC_BITS+3:0]  src_d,
   input  ece_pkg::seg_type      src_seg,
   output ece_pkg::ctl_type      ctl_ff,
   output logic [FRAC_BITS:0]    t_ff,
   output logic [FRAC_BITS:0]    x_ff,
   output logic [FRAC_BITS:0]    sq_ff,
   output logic [FRAC_BITS+1:0]  bnc_ff
);
   import ece_pkg::*;

   localparam int TW = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 4;
   localparam int PW = 2 * TW + 1;
   localparam int QW = 2 * DW + 1;
   localparam logic [PW-1:0] RND  = PW'(1) << (FRAC_BITS - 1);
   localparam logic [QW-1:0] BRND = QW'(1) << (FRAC_BITS + 3);
   localparam logic [TW-1:0] OFS2 = TW'(3) << (FRAC_BITS - 2);
   localparam logic [TW-1:0] OFS3 = TW'(15) << (FRAC_BITS - 4);
   localparam logic [TW-1:0] OFS4 = TW'(63) << (FRAC_BITS - 6);

   logic [PW-1:0] sq_full;
   logic [TW-1:0] sq_in;
   logic [QW-1:0] dsq_full;
   logic [TW-1:0] bpart;
   logic [TW-1:0] ofs;
   logic [TW:0]   bnc_in;

   always_comb begin
      sq_full  = PW'(src_x) * PW'(src_x) + RND;
      sq_in    = sq_full[FRAC_BITS +: TW];
      // Divide by 16 and by one unit, rounding to nearest with ties upward.
      dsq_full = QW'(src_d) * QW'(src_d) + BRND;
      bpart    = dsq_full[FRAC_BITS + 4 +: TW];
      unique case (src_seg)
         SEG_FIRST:  ofs = '0;
         SEG_SECOND: ofs = OFS2;
         SEG_THIRD:  ofs = OFS3;
         SEG_LAST:   ofs = OFS4;
         default:    ofs = '0;
      endcase
      bnc_in = (TW + 1)'(bpart) + (TW + 1)'(ofs);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= src_ctl;
         t_ff   <= src_t;
         x_ff   <= src_x;
         sq_ff  <= sq_in;
         bnc_ff <= bnc_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ece_cube.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator, cube stage
// Forms the rounded cube of the operand and the out-back square term.
// ----------------------------------------------------------------------------
module ece_cube #(
   parameter int FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  ece_pkg::ctl_type      src_ctl,
   input  logic [FRAC_BITS:0]    src_t,
   input  logic [FRAC_BITS:0]    src_x,
   input  logic [FRAC_BITS:0]    src_sq,
   input  logic [FRAC_BITS+1:0]  src_bnc,
   output ece_pkg::ctl_type      ctl_ff,
   output logic [FRAC_BITS:0]    t_ff,
   output logic [FRAC_BITS:0]    sq_ff,
   output logic [FRAC_BITS:0]    cube_ff,
   output logic [FRAC_BITS:0]    c1sq_ff,
   output logic [FRAC_BITS+1:0]  bnc_ff
);
   import ece_pkg::*;

   localparam int TW = FRAC_BITS + 1;
   localparam int PW = 2 * TW + 1;
   localparam logic [33:0]   C1_FULL = back_c1(FRAC_BITS);
   localparam logic [TW-1:0] C1      = C1_FULL[TW-1:0];
   localparam logic [PW-1:0] RND     = PW'(1) << (FRAC_BITS - 1);

   logic [PW-1:0] cube_full;
   logic [PW-1:0] c1sq_full;
   logic [TW-1:0] cube_in;
   logic [TW-1:0] c1sq_in;

   always_comb begin
      cube_full = PW'(src_sq) * PW'(src_x) + RND;
      cube_in   = cube_full[FRAC_BITS +: TW];
      c1sq_full = PW'(C1) * PW'(src_sq) + RND;
      c1sq_in   = c1sq_full[FRAC_BITS +: TW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff  <= src_ctl;
         t_ff    <= src_t;
         sq_ff   <= src_sq;
         cube_ff <= cube_in;
         c1sq_ff <= c1sq_in;
         bnc_ff  <= src_bnc;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ece_result.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Easing curve evaluator, result stages
// Multiplies the cube by one plus the out-back constant, then selects the curve,
// combines the terms and saturates into the output register.
// ----------------------------------------------------------------------------
module ece_result #(
   parameter int FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       en_mul,
   input  logic                       en_out,
   input  ece_pkg::ctl_type           src_ctl,
   input  logic [FRAC_BITS:0]         src_t,
   input  logic [FRAC_BITS:0]         src_sq,
   input  logic [FRAC_BITS:0]         src_cube,
   input  logic [FRAC_BITS:0]         src_c1sq,
   input  logic [FRAC_BITS+1:0]       src_bnc,
   output logic [ece_pkg::OUT_W-1:0]  eased_ff
);
   import ece_pkg::*;

   localparam int TW = FRAC_BITS + 1;
   localparam int PW = 2 * TW + 2;
   localparam int RW = FRAC_BITS + 4;
   localparam int XW = (RW > OUT_W + 1) ? RW : OUT_W + 1;
   localparam logic [33:0]   C1_FULL = back_c1(FRAC_BITS);
   localparam logic [TW:0]   C3      = (TW + 1)'(C1_FULL[TW-1:0]) + ((TW + 1)'(1) << FRAC_BITS);
   localparam logic [TW-1:0] ONE     = TW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] RND     = PW'(1) << (FRAC_BITS - 1);

   // Multiply stage registers.
   ctl_type       ctl_ff;
   logic [TW-1:0] t_ff;
   logic [TW-1:0] sq_ff;
   logic [TW-1:0] cube_ff;
   logic [TW-1:0] c1sq_ff;
   logic [TW:0]   bnc_ff;
   logic [TW:0]   c3v3_ff;

   logic [PW-1:0] c3v3_full;
   logic [TW:0]   c3v3_in;

   always_comb begin
      c3v3_full = PW'(C3) * PW'(src_cube) + RND;
      c3v3_in   = c3v3_full[FRAC_BITS +: TW + 1];
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         ctl_ff  <= src_ctl;
         t_ff    <= src_t;
         sq_ff   <= src_sq;
         cube_ff <= src_cube;
         c1sq_ff <= src_c1sq;
         bnc_ff  <= src_bnc;
         c3v3_ff <= c3v3_in;
      end
   end

   logic signed [RW-1:0]  one_s;
   logic signed [RW-1:0]  t_s;
   logic signed [RW-1:0]  sq_s;
   logic signed [RW-1:0]  cube_s;
   logic signed [RW-1:0]  c1sq_s;
   logic signed [RW-1:0]  c3v3_s;
   logic signed [RW-1:0]  bnc_s;
   logic signed [RW-1:0]  r;
   logic signed [XW-1:0]  rx;
   logic [OUT_W-1:0]      eased_in;

   always_comb begin
      one_s  = RW'(ONE);
      t_s    = RW'(t_ff);
      sq_s   = RW'(sq_ff);
      cube_s = RW'(cube_ff);
      c1sq_s = RW'(c1sq_ff);
      c3v3_s = RW'(c3v3_ff);
      bnc_s  = RW'(bnc_ff);

      unique case (ctl_ff.cmd)
         CURVE_INQUAD:     r = sq_s;
         CURVE_OUTQUAD:    r = one_s - sq_s;
         CURVE_INOUTQUAD:  r = ctl_ff.upper ? (one_s - (sq_s <<< 1)) : (sq_s <<< 1);
         CURVE_INCUBIC:    r = cube_s;
         CURVE_OUTCUBIC:   r = one_s - cube_s;
         CURVE_INOUTCUBIC: r = ctl_ff.upper ? (one_s - (cube_s <<< 2)) : (cube_s <<< 2);
         CURVE_OUTBACK:    r = one_s - c3v3_s + c1sq_s;
         CURVE_OUTBOUNCE:  r = bnc_s;
         default:          r = t_s;
      endcase

      // Out-back can dip slightly below zero through rounding of its terms.
      rx = XW'(r);
      if (rx < 0) begin
         eased_in = '0;
      end else if (rx > XW'(OUT_MAX)) begin
         eased_in = OUT_W'(OUT_MAX);
      end else begin
         eased_in = rx[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         eased_ff <= eased_in;
      end
   end

endmodule
`default_nettype wire
